### hw/rtl/deq_pkg.sv
// Shared types and constants for the double-ended queue unit.
package deq_pkg;

    localparam int DEQ_DEPTH   = 1024;
    localparam int WORD_W      = 32;
    localparam int KIND_W      = 3;
    localparam int OCC_W       = 11;
    localparam int IN_TDATA_W  = 32;
    localparam int IN_TUSER_W  = 8;
    localparam int OUT_TDATA_W = 112;

    localparam logic signed [WORD_W-1:0] NEG_ONE = '1;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_FRONT = 3'd0,
        KIND_PUSH_BACK  = 3'd1,
        KIND_POP_FRONT  = 3'd2,
        KIND_POP_BACK   = 3'd3,
        KIND_QUERY      = 3'd4
    } deq_kind_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] popped;
        logic                     pop_ok;
        logic                     overflow;
        logic [OCC_W-1:0]         occupancy;
        logic                     is_empty;
        logic signed [WORD_W-1:0] front;
        logic signed [WORD_W-1:0] back;
    } deq_result_t;

endpackage

### hw/rtl/deq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/deq_ctrl.sv
// Pointer, count and end-word control for the deque; drives the slot RAM.
module deq_ctrl
    import deq_pkg::*;
#(
    parameter int DEPTH = DEQ_DEPTH,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [KIND_W-1:0]        in_kind,
    input  logic signed [WORD_W-1:0] in_value,
    input  logic                     res_free,
    output logic                     res_valid,
    output deq_result_t              res,
    output logic                     wr_en,
    output logic [AW-1:0]            wr_addr,
    output logic [WORD_W-1:0]        wr_data,
    output logic                     rd_en,
    output logic [AW-1:0]            rd_addr,
    input  logic [WORD_W-1:0]        rd_data
);

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

    state_t                   state_reg, state_next;
    logic [AW-1:0]            head_reg, head_next;
    logic [AW-1:0]            tail_reg, tail_next;
    logic [CW-1:0]            count_reg, count_next;
    logic signed [WORD_W-1:0] front_reg, front_next;
    logic signed [WORD_W-1:0] back_reg, back_next;
    logic signed [WORD_W-1:0] popped_reg, popped_next;
    logic                     side_reg, side_next;   // 1: refill back word

    logic          accept;
    logic          empty, full;
    logic          ok, ovf;
    logic signed [WORD_W-1:0] popped;
    logic [AW-1:0] head_inc, head_dec, tail_inc, tail_dec;
    deq_kind_t     kind;

    assign kind     = deq_kind_t'(in_kind);
    assign in_ready = (state_reg == ST_IDLE) && res_free;
    assign accept   = in_valid && in_ready;
    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CW'(DEPTH));

    // circular index steps
    assign head_inc = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign head_dec = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - 1'b1;
    assign tail_inc = (tail_reg == AW'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
    assign tail_dec = (tail_reg == '0) ? AW'(DEPTH - 1) : tail_reg - 1'b1;

    assign wr_data = in_value;

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        front_next  = front_reg;
        back_next   = back_reg;
        popped_next = popped_reg;
        side_next   = side_reg;
        wr_en       = 1'b0;
        wr_addr     = head_dec;
        rd_en       = 1'b0;
        rd_addr     = head_inc;
        res_valid   = 1'b0;
        ok          = 1'b0;
        ovf         = 1'b0;
        popped      = NEG_ONE;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_valid = 1'b1;
                    unique case (kind)
                        KIND_PUSH_FRONT:
                        begin
                            if (full)
                            begin
                                ovf = 1'b1;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = head_dec;
                                head_next  = head_dec;
                                front_next = in_value;
                                count_next = count_reg + 1'b1;
                                if (empty)
                                begin
                                    tail_next = head_dec;
                                    back_next = in_value;
                                end
                            end
                        end
                        KIND_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                ovf = 1'b1;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = empty ? head_reg : tail_inc;
                                tail_next  = empty ? head_reg : tail_inc;
                                back_next  = in_value;
                                count_next = count_reg + 1'b1;
                                if (empty)
                                begin
                                    front_next = in_value;
                                end
                            end
                        end
                        KIND_POP_FRONT:
                        begin
                            if (!empty)
                            begin
                                ok         = 1'b1;
                                popped     = front_reg;
                                head_next  = head_inc;
                                count_next = count_reg - 1'b1;
                                if (count_reg == CW'(2))
                                begin
                                    front_next = back_reg;
                                end
                                else if (count_reg > CW'(2))
                                begin
                                    // new front lives in the RAM
                                    rd_en       = 1'b1;
                                    rd_addr     = head_inc;
                                    popped_next = front_reg;
                                    side_next   = 1'b0;
                                    res_valid   = 1'b0;
                                    state_next  = ST_READ;
                                end
                            end
                        end
                        KIND_POP_BACK:
                        begin
                            if (!empty)
                            begin
                                ok         = 1'b1;
                                popped     = back_reg;
                                tail_next  = tail_dec;
                                count_next = count_reg - 1'b1;
                                if (count_reg == CW'(2))
                                begin
                                    back_next = front_reg;
                                end
                                else if (count_reg > CW'(2))
                                begin
                                    rd_en       = 1'b1;
                                    rd_addr     = tail_dec;
                                    popped_next = back_reg;
                                    side_next   = 1'b1;
                                    res_valid   = 1'b0;
                                    state_next  = ST_READ;
                                end
                            end
                        end
                        default:
                        begin
                            // query and unused codes leave the state alone
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                res_valid  = 1'b1;
                ok         = 1'b1;
                popped     = popped_reg;
                state_next = ST_IDLE;
                if (side_reg)
                begin
                    back_next = rd_data;
                end
                else
                begin
                    front_next = rd_data;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res.popped    = popped;
        res.pop_ok    = ok;
        res.overflow  = ovf;
        res.occupancy = OCC_W'(count_next);
        res.is_empty  = (count_next == '0);
        res.front     = (count_next == '0) ? NEG_ONE : front_next;
        res.back      = (count_next == '0) ? NEG_ONE : back_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            side_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            side_reg  <= side_next;
        end
    end

    // end-word cache and pending pop word
    always_ff @(posedge clk)
    begin
        front_reg  <= front_next;
        back_reg   <= back_next;
        popped_reg <= popped_next;
    end

endmodule

### hw/rtl/double_ended_queue_unit.sv
// Top level of the double-ended queue unit: control, slot RAM, result register.
//
// Input channel (s_*): one word per operation. s_tuser carries the operation
// code (push front, push back, pop front, pop back, query; unused codes act
// as query), s_tdata carries the word to push.
// Output channel (m_*): exactly one result word per input word, in order:
// popped word and pop flag, overflow flag, occupancy, empty flag, and the
// front and back words after the operation (-1 when empty).
//
// Timing: a result is registered and appears in the cycle after its input is
// accepted, except a pop from more than two words, whose new end word is fetched
// from the slot RAM (registered read) first. Throughput is one operation per cycle
// for pushes, queries and short pops while the receiver takes results; a longer
// pop blocks new input until its read returns. The two end words are cached
// in flops; the RAM is only written on pushes and only read on those pops, so
// a read never targets the entry being written.
//
// Reset empties the queue (head, tail and count cleared); slot contents are
// left as they are. When the receiver stalls, the result stays in the output
// register and s_tready drops until it is taken, so nothing is lost.
module double_ended_queue_unit
    import deq_pkg::*;
#(
    parameter int DEPTH = DEQ_DEPTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [31:0] push_value
    input  logic [IN_TUSER_W-1:0]  s_tuser,   // [2:0] kind, [7:3] zero
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [31:0] popped_value, [32] pop_ok, [33] overflow, [44:34] occupancy,
    // [45] is_empty, [77:46] front_word, [109:78] back_word, [111:110] zero
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic              res_free, res_valid;
    deq_result_t       res;
    deq_result_t       out_reg;
    logic              out_valid_reg;
    logic              wr_en, rd_en;
    logic [AW-1:0]     wr_addr, rd_addr;
    logic [WORD_W-1:0] wr_data, rd_data;

    // result register can take a new word when empty or being drained
    assign res_free = !out_valid_reg || m_tready;

    deq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_kind   (s_tuser[KIND_W-1:0]),
        .in_value  (s_tdata[WORD_W-1:0]),
        .res_free  (res_free),
        .res_valid (res_valid),
        .res       (res),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    deq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg.back, out_reg.front, out_reg.is_empty,
                       out_reg.occupancy, out_reg.overflow, out_reg.pop_ok,
                       out_reg.popped};

endmodule

### hw/rtl/deq_checker.sv
// Port-level checks on the deque result stream, bound to the top level.
module deq_checker
    import deq_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    logic                     ok, ovf, empty;
    logic [OCC_W-1:0]         occ;
    logic signed [WORD_W-1:0] popped, front, back;

    assign popped = m_tdata[31:0];
    assign ok     = m_tdata[32];
    assign ovf    = m_tdata[33];
    assign occ    = m_tdata[44:34];
    assign empty  = m_tdata[45];
    assign front  = m_tdata[77:46];
    assign back   = m_tdata[109:78];

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_pop_xor_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(ok && ovf))
        else $error("pop and overflow flagged together");

    a_failed_pop: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !ok |-> popped == NEG_ONE)
        else $error("popped word without successful pop");

    a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && empty |-> occ == '0 && front == NEG_ONE && back == NEG_ONE)
        else $error("empty result with stale count or end words");

endmodule

bind double_ended_queue_unit deq_checker u_deq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
